// File: rtl/core/moving_average_with_empty_slots_top_macros.svh
// Assertion macros for the checker file of the moving average block.
`ifndef MOVING_AVERAGE_WITH_EMPTY_SLOTS_TOP_MACROS_SVH
`define MOVING_AVERAGE_WITH_EMPTY_SLOTS_TOP_MACROS_SVH

// Clocked property, switched off while reset is high.
`define MAVG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds across reset.
`define MAVG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/mavg_pkg.sv
`timescale 1ns / 1ps
package mavg_pkg;

   // Fixed field widths
   localparam int SAMPLE_BITS = 24;
   localparam int AVG_BITS    = 24;
   localparam int CSR_W       = 5;
   localparam int SUM_W       = SAMPLE_BITS + CSR_W;
   localparam int DIV_CNT_W   = $clog2(SUM_W);

   // Sample value that marks an empty slot
   localparam logic [SAMPLE_BITS-1:0] EMPTY_MARK = SAMPLE_BITS'(16'hFFFF);

   typedef enum logic {
      OP_ADD   = 1'b0,
      OP_CLEAR = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type                    opcode;
      logic signed [SAMPLE_BITS-1:0] sample;
   } req_item_type;

   typedef struct packed {
      logic signed [AVG_BITS-1:0] average;
      logic                       cannot_compute;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STORE,
      ST_SCAN,
      ST_DRAIN,
      ST_DIV_LOAD,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic clear;
      logic store;
      logic scan_init;
      logic scan_read;
      logic div_init;
      logic div_step;
      logic load_out;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_last;
      logic div_last;
      logic out_busy;
   } status_type;

endpackage

// File: rtl/core/moving_average_with_empty_slots_top.sv
`timescale 1ns / 1ps
// Moving average over a ring of MAX_WINDOW slots with empty-slot tracking. An add item
// stores its sample at the write index and returns one result: the truncated mean of
// the occupied slots among the first window_length slots, or zero with cannot_compute
// set when none is occupied; a sample of 65535 is stored but counts as empty. A clear
// item empties every slot and returns nothing. Writing csr_wdata sets the window
// (clamped to 1..MAX_WINDOW) and rewinds the write index; write it only while idle.
// An add item occupies the block from acceptance until its result is loaded into the
// result register: the slots are read one a cycle through the single read port of
// the slot memory, and the divider yields one quotient bit a cycle over the 29-bit
// sum. The result register lets a new item enter while the last result waits to be
// taken.
module moving_average_with_empty_slots_top #(
   parameter int MAX_WINDOW = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  mavg_pkg::req_item_type       req_item,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output mavg_pkg::rsp_item_type       rsp_item,
   input  logic                         csr_we,
   input  logic [mavg_pkg::CSR_W-1:0]   csr_wdata
);
   import mavg_pkg::*;

   cmd_type    cmd;
   status_type status;

   mavg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_item.opcode),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   mavg_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_item  (req_item),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// File: rtl/core/mavg_ctrl.sv
`timescale 1ns / 1ps
module mavg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  mavg_pkg::opcode_type   req_opcode,
   output logic                   req_ready,
   input  mavg_pkg::status_type   status,
   output mavg_pkg::cmd_type      cmd
);
   import mavg_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = req_valid && req_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_opcode == OP_ADD) state_in = ST_STORE;
         end
         ST_STORE: state_in = ST_SCAN;
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_DIV_LOAD;
         ST_DIV_LOAD: state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (status.div_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid && req_opcode == OP_ADD;
            cmd.clear   = req_valid && req_opcode == OP_CLEAR;
         end
         ST_STORE: begin
            cmd.store     = 1'b1;
            cmd.scan_init = 1'b1;
         end
         ST_SCAN: cmd.scan_read = 1'b1;
         ST_DRAIN: cmd = '0;
         ST_DIV_LOAD: cmd.div_init = 1'b1;
         ST_DIVIDE: cmd.div_step = 1'b1;
         ST_FINISH: cmd.load_out = !status.out_busy;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/mavg_datapath.sv
`timescale 1ns / 1ps
module mavg_datapath #(
   parameter int MAX_WINDOW = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [mavg_pkg::CSR_W-1:0]   csr_wdata,
   input  mavg_pkg::req_item_type       req_item,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output mavg_pkg::rsp_item_type       rsp_item,
   input  mavg_pkg::cmd_type            cmd,
   output mavg_pkg::status_type         status
);
   import mavg_pkg::*;

   localparam int IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CMP_W   = (IDX_W + 1 > CSR_W) ? IDX_W + 1 : CSR_W;
   localparam int WIN_RST = (MAX_WINDOW < 16) ? MAX_WINDOW : 16;

   logic [CSR_W-1:0]       window_ff, window_in;
   logic [IDX_W-1:0]       wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]       wr_eff;
   logic [CMP_W-1:0]       wr_next;
   logic [CMP_W-1:0]       csr_cmp;
   req_item_type           item_ff, item_in;
   logic [SAMPLE_BITS-1:0] slot_mem [MAX_WINDOW];
   logic [MAX_WINDOW-1:0]  valid_ff, valid_in;
   logic [IDX_W-1:0]       scan_idx_ff, scan_idx_in;
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic                   rd_valid_ff;
   logic                   rd_live_ff, rd_live_in;
   logic [SUM_W-1:0]       acc_ff, acc_in;
   logic [CSR_W-1:0]       cnt_ff, cnt_in;
   logic [SUM_W-1:0]       quo_ff, quo_in;
   logic [CSR_W:0]         rem_ff, rem_in;
   logic [CSR_W:0]         rem_shift;
   logic                   neg_ff, neg_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic [SUM_W-1:0]       quo_signed;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_item_type           rsp_item_ff, rsp_item_in;

   // Clamp the window write to 1..MAX_WINDOW
   always_comb begin
      csr_cmp   = CMP_W'(csr_wdata);
      window_in = window_ff;
      if (csr_we) begin
         if (csr_wdata == '0) begin
            window_in = CSR_W'(1);
         end else if (csr_cmp > CMP_W'(MAX_WINDOW)) begin
            window_in = CSR_W'(MAX_WINDOW);
         end else begin
            window_in = csr_wdata;
         end
      end
   end

   // Write index: fold back into the window, advance with wrap
   always_comb begin
      wr_eff    = (CMP_W'(wr_idx_ff) >= CMP_W'(window_ff)) ? '0 : wr_idx_ff;
      wr_next   = CMP_W'(wr_eff) + CMP_W'(1);
      wr_idx_in = wr_idx_ff;
      if (csr_we) begin
         wr_idx_in = '0;
      end else if (cmd.store) begin
         wr_idx_in = (wr_next == CMP_W'(window_ff)) ? '0 : IDX_W'(wr_next);
      end
   end

   // Hold the accepted item
   assign item_in = cmd.capture ? req_item : item_ff;

   // Slot occupancy: clear empties every slot, store fills one
   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear) begin
         valid_in = '0;
      end else if (cmd.store) begin
         valid_in[wr_eff] = 1'b1;
      end
   end

   // Slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         slot_mem[wr_eff] <= item_ff.sample;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff  <= slot_mem[scan_idx_ff];
      rd_valid_ff <= valid_ff[scan_idx_ff];
   end

   // Scan the window and accumulate occupied slots
   always_comb begin
      scan_idx_in = scan_idx_ff;
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      rd_live_in  = cmd.scan_read;
      if (cmd.scan_init) begin
         scan_idx_in = '0;
         acc_in      = '0;
         cnt_in      = '0;
      end else begin
         if (cmd.scan_read) scan_idx_in = scan_idx_ff + IDX_W'(1);
         if (rd_live_ff && rd_valid_ff && rd_data_ff != EMPTY_MARK) begin
            acc_in = acc_ff + {{CSR_W{rd_data_ff[SAMPLE_BITS-1]}}, rd_data_ff};
            cnt_in = cnt_ff + CSR_W'(1);
         end
      end
   end

   // Restoring divide of |sum| by the count, one quotient bit a cycle
   always_comb begin
      rem_shift  = {rem_ff[CSR_W-1:0], quo_ff[SUM_W-1]};
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      neg_in     = neg_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.div_init) begin
         neg_in     = acc_ff[SUM_W-1];
         quo_in     = acc_ff[SUM_W-1] ? (~acc_ff + SUM_W'(1)) : acc_ff;
         rem_in     = '0;
         div_cnt_in = DIV_CNT_W'(SUM_W - 1);
      end else if (cmd.div_step) begin
         div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
         if (rem_shift >= {1'b0, cnt_ff}) begin
            rem_in = rem_shift - {1'b0, cnt_ff};
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
      end
   end

   // Result register: restore sign, flag an empty window
   always_comb begin
      quo_signed   = neg_ff ? (~quo_ff + SUM_W'(1)) : quo_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in               = 1'b1;
         rsp_item_in.cannot_compute = (cnt_ff == '0);
         rsp_item_in.average        = (cnt_ff == '0) ? '0 : quo_signed[AVG_BITS-1:0];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign status.scan_last = (CMP_W'(scan_idx_ff) + CMP_W'(1)) == CMP_W'(window_ff);
   assign status.div_last  = (div_cnt_ff == '0);
   assign status.out_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= CSR_W'(WIN_RST);
         wr_idx_ff    <= '0;
         valid_ff     <= '0;
         rd_live_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         wr_idx_ff    <= wr_idx_in;
         valid_ff     <= valid_in;
         rd_live_ff   <= rd_live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      scan_idx_ff <= scan_idx_in;
      acc_ff      <= acc_in;
      cnt_ff      <= cnt_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      div_cnt_ff  <= div_cnt_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule

// File: rtl/core/mavg_checker.sv
`timescale 1ns / 1ps
`include "moving_average_with_empty_slots_top_macros.svh"
module mavg_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input mavg_pkg::req_item_type   req_item,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input mavg_pkg::rsp_item_type   rsp_item
);
   import mavg_pkg::*;

   // A waiting result stays put until taken
   property p_rsp_hold;
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item);
   endproperty

   // An add item keeps the block busy on the next cycle
   property p_add_busy;
      req_valid && req_ready && req_item.opcode == OP_ADD |=> !req_ready;
   endproperty

   // A clear item produces no result
   property p_clear_silent;
      req_valid && req_ready && req_item.opcode == OP_CLEAR && !rsp_valid |=> !rsp_valid;
   endproperty

   // An empty window reports a zero average
   property p_empty_zero;
      rsp_valid && rsp_item.cannot_compute |-> rsp_item.average == '0;
   endproperty

   `MAVG_ASSERT(a_rsp_hold, clock, reset, p_rsp_hold, "result changed while stalled")
   `MAVG_ASSERT(a_add_busy, clock, reset, p_add_busy, "input taken again straight after an add item")
   `MAVG_ASSERT(a_clear_silent, clock, reset, p_clear_silent, "clear item produced a result")
   `MAVG_ASSERT(a_empty_zero, clock, reset, p_empty_zero, "nonzero average with cannot_compute set")

   // Reset drops any pending result
   `MAVG_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind moving_average_with_empty_slots_top mavg_checker u_mavg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

// File: tb/moving_average_with_empty_slots_checker.sv
`timescale 1ns / 1ps
module moving_average_with_empty_slots_checker #(
   parameter int MAX_WINDOW = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  mavg_pkg::req_item_type       req_item,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  mavg_pkg::rsp_item_type       rsp_item,
   input  logic                         csr_we,
   input  logic [mavg_pkg::CSR_W-1:0]   csr_wdata,
   output int                           mismatch_count,
   output int                           pending_count
);

   // Shadow copy of the slot ring, write pointer and window register
   logic [mavg_pkg::SAMPLE_BITS-1:0] slot_store [MAX_WINDOW];
   int unsigned                      write_pos;
   int unsigned                      window_len;

   // Averages still owed by the block, oldest first
   mavg_pkg::rsp_item_type expected_averages [$];
   int                     mismatch_tally = 0;

   task automatic empty_slots();
      for (int i = 0; i < MAX_WINDOW; i++) begin
         slot_store[i] = mavg_pkg::EMPTY_MARK;
      end
   endtask

   // Apply one accepted item to the shadow ring and queue the average it yields
   task automatic predict_average(input mavg_pkg::req_item_type item);
      longint                 total;
      longint                 mean;
      int                     occupied;
      mavg_pkg::rsp_item_type result;
      total    = 0;
      occupied = 0;
      mean     = 0;
      result   = '0;
      if (item.opcode == mavg_pkg::OP_CLEAR) begin
         // clear keeps the write pointer and owes nothing
         empty_slots();
      end else begin
         if (write_pos >= window_len || write_pos >= MAX_WINDOW) begin
            write_pos = 0;
         end
         slot_store[write_pos] = item.sample;
         write_pos = (write_pos + 1) % window_len;
         // sum the occupied slots inside the window only
         for (int i = 0; i < window_len && i < MAX_WINDOW; i++) begin
            if (slot_store[i] != mavg_pkg::EMPTY_MARK) begin
               total += longint'($signed(slot_store[i]));
               occupied++;
            end
         end
         if (occupied > 0) begin
            mean = total / occupied;
            result.cannot_compute = 1'b0;
         end else begin
            result.cannot_compute = 1'b1;
         end
         result.average = mean[mavg_pkg::AVG_BITS-1:0];
         expected_averages.push_back(result);
      end
   endtask

   always @(posedge clock) begin
      mavg_pkg::rsp_item_type want;
      if (reset) begin
         empty_slots();
         write_pos  = 0;
         window_len = (MAX_WINDOW < 16) ? MAX_WINDOW : 16;
         expected_averages.delete();
      end else begin
         // window write: clamp into 1..MAX_WINDOW and rewind the pointer
         if (csr_we) begin
            if (csr_wdata == 0) begin
               window_len = 1;
            end else if (csr_wdata > MAX_WINDOW) begin
               window_len = MAX_WINDOW;
            end else begin
               window_len = csr_wdata;
            end
            write_pos = 0;
         end
         // compare each taken result with the oldest owed average
         if (rsp_valid && rsp_ready) begin
            if (expected_averages.size() == 0) begin
               $error("result with no average owed: average %0d, cannot_compute %0b",
                      rsp_item.average, rsp_item.cannot_compute);
               mismatch_tally++;
            end else begin
               want = expected_averages.pop_front();
               if (rsp_item.average !== want.average) begin
                  $error("average: expected %0d, got %0d", want.average, rsp_item.average);
                  mismatch_tally++;
               end
               if (rsp_item.cannot_compute !== want.cannot_compute) begin
                  $error("cannot_compute: expected %0b, got %0b",
                         want.cannot_compute, rsp_item.cannot_compute);
                  mismatch_tally++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_average(req_item);
         end
      end
      // publish after the edge so the stimulus side never races the update
      pending_count  <= expected_averages.size();
      mismatch_count <= mismatch_tally;
   end

endmodule

// File: tb/tb_moving_average_with_empty_slots_top.sv
`timescale 1ns / 1ps
module tb_moving_average_with_empty_slots_top;
   import mavg_pkg::*;

   localparam int MAX_WINDOW    = 16;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 64;
   localparam int PHASE_ITEMS   = 104;
   localparam int MAX_GAP       = 60;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   req_item_type       req_item  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rsp_item_type       rsp_item;
   logic               csr_we    = 1'b0;
   logic [CSR_W-1:0]   csr_wdata = '0;

   int mismatch_count;
   int pending_count;
   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int cycle_count       = 0;

   always #10 clock = ~clock;

   moving_average_with_empty_slots_top #(
      .MAX_WINDOW (MAX_WINDOW)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   moving_average_with_empty_slots_checker #(
      .MAX_WINDOW (MAX_WINDOW)
   ) average_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_item       (rsp_item),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // Stall the result side at the current rate
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // Give up on a hung block
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic req_item_type make_item(input opcode_type op,
                                               input logic [SAMPLE_BITS-1:0] value);
      req_item_type item;
      item.opcode = op;
      item.sample = value;
      return item;
   endfunction

   // Bias towards the empty mark, the extremes and small values of either sign
   function automatic logic [SAMPLE_BITS-1:0] random_sample();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 12) begin
         return EMPTY_MARK;
      end else if (pick < 20) begin
         return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else if (pick < 28) begin
         return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else if (pick < 45) begin
         return SAMPLE_BITS'(int'($urandom_range(200)) - 100);
      end else begin
         return SAMPLE_BITS'($urandom());
      end
   endfunction

   // Idle for a random spell, then hold the item until it is taken
   task automatic send_item(input req_item_type item);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   task automatic add_sample(input int value);
      send_item(make_item(OP_ADD, SAMPLE_BITS'(value)));
   endtask

   // Drop valid and hold until every owed average has been taken
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
   endtask

   // Window writes only once the block has gone quiet
   task automatic set_window(input logic [CSR_W-1:0] code);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= code;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic run_phase(input logic [CSR_W-1:0] code, input int snd_pct,
                            input int rcv_pct, input bit pause_midway);
      set_window(code);
      sender_idle_pct   = snd_pct;
      receiver_idle_pct = rcv_pct;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (pause_midway && n == PHASE_ITEMS / 2) begin
            wait_drained();
         end
         if ($urandom_range(99) < 4) begin
            send_item(make_item(OP_CLEAR, SAMPLE_BITS'($urandom())));
         end else begin
            send_item(make_item(OP_ADD, random_sample()));
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      sender_idle_pct   = 18;
      receiver_idle_pct = 86;

      // default window of 16: extremes, empty mark and its neighbours
      add_sample(0);
      add_sample(8388607);
      add_sample(-8388608);
      add_sample(65535);
      add_sample(-1);
      add_sample(65534);
      add_sample(65536);
      // clear ignores its sample; an empty mark then leaves nothing to average
      send_item(make_item(OP_CLEAR, SAMPLE_BITS'($urandom())));
      add_sample(65535);
      // negative mean truncates towards zero
      add_sample(-5);
      add_sample(2);

      // window code 0 clamps to one slot
      set_window('0);
      add_sample(8388607);
      add_sample(65535);
      add_sample(-8388608);

      // code above the maximum clamps; slots left outside the window come back
      set_window(5'd17);
      add_sample(7);

      // short window wraps and overwrites its first slot
      set_window(5'd3);
      add_sample(10);
      add_sample(20);
      add_sample(30);
      add_sample(40);
      send_item(make_item(OP_CLEAR, SAMPLE_BITS'($urandom())));

      // random phases: slow receiver, then slow sender, then flat out
      run_phase(5'd31, 18, 86, 1'b0);
      run_phase(5'd1, 18, 86, 1'b0);
      run_phase(5'd2, 18, 86, 1'b0);
      run_phase(5'd5, 86, 18, 1'b0);
      run_phase(5'd16, 86, 18, 1'b1);
      run_phase(5'd8, 86, 18, 1'b0);
      run_phase(5'd15, 0, 0, 1'b0);
      run_phase(5'd4, 0, 0, 1'b0);
      run_phase(5'd9, 0, 0, 1'b0);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
